@@ rtl/ps_string_token_decoder_core_assert.svh @@
// assertion macros for the rtl
`ifndef PS_STRING_TOKEN_DECODER_CORE_ASSERT_SVH
`define PS_STRING_TOKEN_DECODER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PSTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PSTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pstd_pkg.sv @@
`default_nettype none

package pstd_pkg;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LT   = 2'd1;
    localparam logic [1:0] MODE_LIT  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_BSL  = 2'd1;
    localparam logic [1:0] ESC_OCT  = 2'd2;

    localparam logic [2:0] ST_RUN        = 3'd0;
    localparam logic [2:0] ST_CLOSED     = 3'd1;
    localparam logic [2:0] ST_LONG       = 3'd2;
    localparam logic [2:0] ST_NOT_STRING = 3'd3;
    localparam logic [2:0] ST_ASCII85    = 3'd4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]  mode;
        logic [16:0] paren_depth;
        logic [1:0]  escape_phase;
        logic [8:0]  octal_value;
        logic [1:0]  octal_digits;
        logic        after_cr;
        logic [4:0]  high_nibble;
        logic [15:0] byte_count;
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [2:0] status;
        logic       bad_hex_digit;
        logic       last;
    } t_result;

    typedef struct packed {
        t_result    res0;
        t_result    res1;
        logic [1:0] nres;
        logic [2:0] status;
    } t_step_out;

    // bit 4 flags a bad digit, bits 3..0 the digit value
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b0, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pstd_if.sv @@
`default_nettype none

interface pstd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       token_start;
    logic       buffer_end;
    modport source (output valid, in_byte, token_start, buffer_end, input ready);
    modport sink (input valid, in_byte, token_start, buffer_end, output ready);
endinterface

interface pstd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
    logic       bad_hex_digit;
    logic       last;
    modport source (output valid, out_byte, out_valid, status, bad_hex_digit, last,
                    input ready);
    modport sink (input valid, out_byte, out_valid, status, bad_hex_digit, last,
                  output ready);
endinterface

interface pstd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_length;
    modport source (output valid, max_length, input ready);
    modport sink (input valid, max_length, output ready);
endinterface

`default_nettype wire

@@ rtl/pstd_step.sv @@
`default_nettype none

module pstd_step
    import pstd_pkg::*;
(
    input  t_state      i_state,
    input  logic [15:0] i_max_length,
    input  logic [7:0]  i_byte,
    input  logic        i_token_start,
    input  logic        i_buffer_end,
    output t_state      o_state,
    output t_step_out   o_step
);

    t_state      ns;
    logic [2:0]  st;
    logic        bad;
    logic        req1, req2;
    logic [7:0]  val1, val2;
    logic        paren_inc;
    logic        hex_go, lit_go;
    logic        oct_cont;
    logic        is_oct;
    logic        is_white;
    logic [8:0]  ov_next;
    logic [16:0] depth_dec;
    logic [4:0]  hv;
    logic        fail1, fail2, failed;
    logic        ok1, ok2;
    logic [15:0] cnt1;
    logic        none;

    assign is_oct = (i_byte >= 8'h30) && (i_byte <= 8'h37);
    assign is_white = (i_byte == CH_NUL) || (i_byte == CH_TAB) || (i_byte == CH_LF) ||
                      (i_byte == CH_FF) || (i_byte == CH_CR) || (i_byte == CH_SPACE);
    assign ov_next = {i_state.octal_value[5:0], i_byte[2:0]};
    assign depth_dec = (i_state.paren_depth != '0) ? 17'(i_state.paren_depth - 17'd1)
                                                   : i_state.paren_depth;
    assign hv = hex_val(i_byte);

    always_comb begin
        ns        = i_state;
        st        = ST_RUN;
        bad       = 1'b0;
        req1      = 1'b0;
        req2      = 1'b0;
        val1      = '0;
        val2      = '0;
        paren_inc = 1'b0;
        hex_go    = 1'b0;
        lit_go    = 1'b0;
        oct_cont  = 1'b0;
        none      = 1'b0;

        if (i_token_start) begin
            ns = '0;
            if (i_byte == CH_LPAREN) begin
                ns.mode        = MODE_LIT;
                ns.paren_depth = 17'd1;
            end else if (i_byte == CH_LT) begin
                ns.mode = MODE_LT;
            end else begin
                st = ST_NOT_STRING;
            end
        end else begin
            unique case (i_state.mode)
                MODE_IDLE: none = 1'b1;
                MODE_LT: begin
                    if (i_byte == CH_LT) begin
                        st = ST_NOT_STRING;
                    end else if (i_byte == CH_TILDE) begin
                        st = ST_ASCII85;
                    end else begin
                        ns.mode = MODE_HEX;
                        hex_go  = 1'b1;
                    end
                end
                MODE_LIT: lit_go = 1'b1;
                MODE_HEX: hex_go = 1'b1;
            endcase
        end

        // hex string digit pairs
        if (hex_go && !is_white) begin
            if (i_byte == CH_GT) begin
                if (i_state.high_nibble[4]) begin
                    req2 = 1'b1;
                    val2 = {i_state.high_nibble[3:0], 4'h0};
                end
                ns.high_nibble = '0;
                st = ST_CLOSED;
            end else begin
                bad = hv[4];
                if (i_state.high_nibble[4]) begin
                    req2 = 1'b1;
                    val2 = {i_state.high_nibble[3:0], hv[3:0]};
                    ns.high_nibble = '0;
                end else begin
                    ns.high_nibble = {1'b1, hv[3:0]};
                end
            end
        end

        // literal string
        if (lit_go) begin
            if (i_state.after_cr && i_byte == CH_LF) begin
                ns.after_cr = 1'b0;
            end else begin
                ns.after_cr = 1'b0;
                if (i_state.escape_phase == ESC_OCT) begin
                    if (is_oct) begin
                        oct_cont = 1'b1;
                        if (i_state.octal_digits == 2'd2) begin
                            req1 = 1'b1;
                            val1 = ov_next[7:0];
                            ns.escape_phase = ESC_NONE;
                            ns.octal_value  = '0;
                            ns.octal_digits = '0;
                        end else begin
                            ns.octal_value  = ov_next;
                            ns.octal_digits = 2'(i_state.octal_digits + 2'd1);
                        end
                    end else begin
                        req1 = 1'b1;
                        val1 = i_state.octal_value[7:0];
                        ns.escape_phase = ESC_NONE;
                        ns.octal_value  = '0;
                        ns.octal_digits = '0;
                    end
                end
                if (!oct_cont) begin
                    if (i_state.escape_phase == ESC_BSL) begin
                        ns.escape_phase = ESC_NONE;
                        case (i_byte)
                            CH_N: begin req2 = 1'b1; val2 = CH_LF;  end
                            CH_R: begin req2 = 1'b1; val2 = CH_CR;  end
                            CH_T: begin req2 = 1'b1; val2 = CH_TAB; end
                            CH_B: begin req2 = 1'b1; val2 = CH_BS;  end
                            CH_F: begin req2 = 1'b1; val2 = CH_FF;  end
                            CH_LF: ;
                            CH_CR: ns.after_cr = 1'b1;
                            default: begin
                                if (is_oct) begin
                                    ns.escape_phase = ESC_OCT;
                                    ns.octal_value  = {6'd0, i_byte[2:0]};
                                    ns.octal_digits = 2'd1;
                                end else begin
                                    req2 = 1'b1;
                                    val2 = i_byte;
                                end
                            end
                        endcase
                    end else begin
                        case (i_byte)
                            CH_BSLASH: ns.escape_phase = ESC_BSL;
                            CH_LPAREN: begin
                                req2      = 1'b1;
                                val2      = i_byte;
                                paren_inc = 1'b1;
                            end
                            CH_RPAREN: begin
                                ns.paren_depth = depth_dec;
                                if (depth_dec == '0) begin
                                    st = ST_CLOSED;
                                end else begin
                                    req2 = 1'b1;
                                    val2 = i_byte;
                                end
                            end
                            CH_CR: begin
                                req2        = 1'b1;
                                val2        = CH_LF;
                                ns.after_cr = 1'b1;
                            end
                            default: begin
                                req2 = 1'b1;
                                val2 = i_byte;
                            end
                        endcase
                    end
                end
            end
        end

        // length limit on emitted bytes
        fail1  = req1 && (i_state.byte_count >= i_max_length);
        ok1    = req1 && !fail1;
        cnt1   = ok1 ? 16'(i_state.byte_count + 16'd1) : i_state.byte_count;
        fail2  = req2 && !fail1 && (cnt1 >= i_max_length);
        failed = fail1 || fail2;
        ok2    = req2 && !failed;
        if (lit_go || hex_go) begin
            ns.byte_count = ok2 ? 16'(cnt1 + 16'd1) : cnt1;
        end
        if (paren_inc && !failed) begin
            ns.paren_depth = 17'(i_state.paren_depth + 17'd1);
        end

        if (failed) st = ST_LONG;
        if (st == ST_RUN && i_buffer_end) st = ST_LONG;
        if (st != ST_RUN) ns = '0;

        o_step.status = st;
        o_step.res0   = '0;
        o_step.res1   = '0;
        if (none) begin
            o_step.nres = 2'd0;
        end else if (ok1 && ok2) begin
            o_step.nres = 2'd2;
            o_step.res0 = '{out_byte: val1, out_valid: 1'b1, status: ST_RUN,
                            bad_hex_digit: 1'b0, last: 1'b0};
            o_step.res1 = '{out_byte: val2, out_valid: 1'b1, status: st,
                            bad_hex_digit: bad, last: 1'b1};
        end else if (ok1 || ok2) begin
            o_step.nres = 2'd1;
            o_step.res0 = '{out_byte: ok1 ? val1 : val2, out_valid: 1'b1, status: st,
                            bad_hex_digit: bad, last: 1'b1};
        end else begin
            o_step.nres = 2'd1;
            o_step.res0 = '{out_byte: 8'h00, out_valid: 1'b0, status: st,
                            bad_hex_digit: bad, last: 1'b1};
        end
    end

    assign o_state = ns;

endmodule

`default_nettype wire

@@ rtl/ps_string_token_decoder_core.sv @@
// string token decoder: one raw byte in per transfer on i_in, decoded results
// out on o_out, one per transfer. a byte yields no result when no token is
// open, otherwise one or two results; the final one has last set and carries
// status and bad_hex_digit. i_cfg writes max_length and is always ready;
// write it only while the block is idle.
// a byte is captured in the input register, decoded combinationally from it
// and written into a four-entry result queue, whose head is offered on o_out.
// throughput: one byte per cycle as long as the sink drains one result per
// cycle; a byte that yields two results needs two output transfers. the
// decode step waits while the queue holds more than two results.
// reset: synchronous, active low; clears the token state, empties the queue
// and restores max_length to 4096.
// a stalled sink fills the queue, then the input register holds its byte
// and i_in.ready drops; nothing is lost or reordered.
`default_nettype none
`include "ps_string_token_decoder_core_assert.svh"

module ps_string_token_decoder_core
    import pstd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pstd_in_if.sink     i_in,
    pstd_out_if.source  o_out,
    pstd_cfg_if.sink    i_cfg
);

    logic              r_in_valid;
    logic [7:0]        r_byte;
    logic              r_start;
    logic              r_bend;
    t_state            r_state;
    t_state            n_state;
    t_step_out         w_step;
    logic [15:0]       r_max_length;
    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              w_fire;
    logic              w_pop;
    logic [1:0]        w_push;

    assign w_fire = r_in_valid && (r_count <= QCNT_W'(QDEPTH - 2));
    assign i_in.ready = !r_in_valid || w_fire;
    assign i_cfg.ready = 1'b1;

    assign w_pop  = o_out.valid && o_out.ready;
    assign w_push = w_fire ? w_step.nres : 2'd0;
    assign n_count = QCNT_W'(r_count + QCNT_W'(w_push) - QCNT_W'(w_pop));

    pstd_step u_step (
        .i_state       (r_state),
        .i_max_length  (r_max_length),
        .i_byte        (r_byte),
        .i_token_start (r_start),
        .i_buffer_end  (r_bend),
        .o_state       (n_state),
        .o_step        (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_state      <= '0;
            r_max_length <= MAX_LENGTH_RESET;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (w_fire) r_state <= n_state;
            if (i_cfg.valid) r_max_length <= i_cfg.max_length;
            r_wr_ptr <= QPTR_W'(r_wr_ptr + QPTR_W'(w_push));
            if (w_pop) r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte  <= i_in.in_byte;
            r_start <= i_in.token_start;
            r_bend  <= i_in.buffer_end;
        end
        if (w_push != 2'd0) r_q[r_wr_ptr] <= w_step.res0;
        if (w_push == 2'd2) r_q[QPTR_W'(r_wr_ptr + 1'b1)] <= w_step.res1;
    end

    assign o_out.valid         = (r_count != '0);
    assign o_out.out_byte      = r_q[r_rd_ptr].out_byte;
    assign o_out.out_valid     = r_q[r_rd_ptr].out_valid;
    assign o_out.status        = r_q[r_rd_ptr].status;
    assign o_out.bad_hex_digit = r_q[r_rd_ptr].bad_hex_digit;
    assign o_out.last          = r_q[r_rd_ptr].last;

    `PSTD_ASSERT_NOW(a_queue_bound, 1'b1, r_count <= QCNT_W'(QDEPTH), "result queue overflow")
    `PSTD_ASSERT_NOW(a_pair_whole, (r_count != '0) && !r_q[r_rd_ptr].last,
        r_count >= QCNT_W'(2), "queue head not last but its partner is missing")
    `PSTD_ASSERT_NEXT(a_close_idle, w_fire && (w_step.status != ST_RUN),
        r_state.mode == MODE_IDLE, "token still open after a final status")
    `PSTD_ASSERT_NOW(a_depth_lit, r_state.mode != MODE_LIT, r_state.paren_depth == '0,
        "paren depth left over outside a literal string")

endmodule

`default_nettype wire
